// ===== rtl/core/srpd_pkg.sv =====
package srpd_pkg;

	localparam int RELAY_COUNT_DEF = 6;
	localparam int SLOT_BITS_DEF   = 24;

	localparam int CFG_RELAYS = 6;
	localparam int LEN_W      = 16;
	localparam int SEL_W      = 3;
	localparam int IDX_W      = 3;

	localparam logic [LEN_W-1:0] PULSE_LEN_RESET = 16'd100;
	localparam logic [LEN_W-1:0] GAP_RESET       = 16'd50;

	localparam logic [IDX_W-1:0] REG_IMPULSE_MASK = 3'd0;
	localparam logic [IDX_W-1:0] REG_PULSE_LEN_0  = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAP          = 3'd7;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_SEL = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [SEL_W-1:0] relay_sel;
		logic             turn_on;
	} in_item_t;

	typedef struct packed {
		logic [CFG_RELAYS-1:0] coil_levels;
		logic [CFG_RELAYS-1:0] logical_states;
		logic                  status;
	} out_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [LEN_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic tick;
		logic restart;
	} chan_cmd_t;

endpackage

// ===== rtl/core/srpd_stream_if.sv =====
interface srpd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/srpd_cfg_regs.sv =====
module srpd_cfg_regs import srpd_pkg::*; #(
	parameter int RELAY_COUNT = RELAY_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  cfg_wr_t                           wr,
	output logic [RELAY_COUNT-1:0]            impulse_mask,
	output logic [RELAY_COUNT-1:0][LEN_W-1:0] pulse_len,
	output logic [LEN_W-1:0]                  gap_ms
);

	logic [CFG_RELAYS-1:0] mask_q;
	logic [LEN_W-1:0]      gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			gap_q  <= GAP_RESET;
		end else if (wr_en) begin
			if (wr.index == REG_IMPULSE_MASK) begin
				mask_q <= wr.data[CFG_RELAYS-1:0];
			end
			if (wr.index == REG_GAP) begin
				gap_q <= wr.data;
			end
		end
	end

	assign gap_ms = gap_q;

	for (genvar ch = 0; ch < RELAY_COUNT; ch++) begin : g_chan
		if (ch < CFG_RELAYS) begin : g_cfg
			localparam logic [IDX_W-1:0] LEN_IDX = IDX_W'(int'(REG_PULSE_LEN_0) + ch);
			logic [LEN_W-1:0] len_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					len_q <= PULSE_LEN_RESET;
				end else if (wr_en && wr.index == LEN_IDX) begin
					len_q <= wr.data;
				end
			end

			assign pulse_len[ch]    = len_q;
			assign impulse_mask[ch] = mask_q[ch];
		end else begin : g_fixed
			// extra relays: fixed length, always level driven
			assign pulse_len[ch]    = PULSE_LEN_RESET;
			assign impulse_mask[ch] = 1'b0;
		end
	end

endmodule

// ===== rtl/core/srpd_slot.sv =====
module srpd_slot import srpd_pkg::*; #(
	parameter int SLOT_BITS = SLOT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic                 reserve,
	input  logic [LEN_W-1:0]     pulse_len,
	input  logic [LEN_W-1:0]     gap_ms,
	output logic [SLOT_BITS-1:0] slot_wait
);

	localparam logic [SLOT_BITS-1:0] SLOT_MAX = '1;
	localparam logic [SLOT_BITS-1:0] SLOT_ONE = SLOT_BITS'(1);

	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS-1:0] slot_d;
	logic [SLOT_BITS:0]   sum;

	assign sum = {1'b0, slot_q} + (SLOT_BITS+1)'(pulse_len) + (SLOT_BITS+1)'(gap_ms);

	always_comb begin
		slot_d = slot_q;
		if (tick && slot_q != '0) begin
			slot_d = slot_q - SLOT_ONE;
		end else if (reserve) begin
			// saturate at the top of the countdown
			slot_d = sum[SLOT_BITS] ? SLOT_MAX : sum[SLOT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

	assign slot_wait = slot_q;

endmodule

// ===== rtl/core/srpd_chan.sv =====
module srpd_chan import srpd_pkg::*; #(
	parameter int SLOT_BITS = SLOT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chan_cmd_t            cmd,
	input  logic [SLOT_BITS-1:0] delay,
	input  logic [LEN_W-1:0]     pulse_len,
	output logic                 coil_d
);

	localparam logic [SLOT_BITS-1:0] WAIT_ONE = SLOT_BITS'(1);
	localparam logic [LEN_W-1:0]     LEFT_ONE = LEN_W'(1);

	logic                 pending_q;
	logic [SLOT_BITS-1:0] wait_q;
	logic [LEN_W-1:0]     left_q;
	logic                 coil_q;

	logic                 pending_d;
	logic [SLOT_BITS-1:0] wait_d;
	logic [LEN_W-1:0]     left_d;
	logic                 coil_n;

	always_comb begin
		pending_d = pending_q;
		wait_d    = wait_q;
		left_d    = left_q;
		coil_n    = coil_q;
		if (cmd.tick) begin
			if (coil_q) begin
				if (left_q <= LEFT_ONE) begin
					left_d = '0;
					coil_n = 1'b0;
				end else begin
					left_d = left_q - LEFT_ONE;
				end
			end
			if (pending_q) begin
				if (wait_q <= WAIT_ONE) begin
					wait_d    = '0;
					pending_d = 1'b0;
					coil_n    = 1'b1;
					left_d    = pulse_len;
				end else begin
					wait_d = wait_q - WAIT_ONE;
				end
			end
		end else if (cmd.restart) begin
			// drop whatever was pending or running, then queue or fire
			if (delay != '0) begin
				pending_d = 1'b1;
				wait_d    = delay;
				left_d    = '0;
				coil_n    = 1'b0;
			end else begin
				pending_d = 1'b0;
				wait_d    = '0;
				left_d    = pulse_len;
				coil_n    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			wait_q    <= '0;
			left_q    <= '0;
			coil_q    <= 1'b0;
		end else begin
			pending_q <= pending_d;
			wait_q    <= wait_d;
			left_q    <= left_d;
			coil_q    <= coil_n;
		end
	end

	assign coil_d = coil_n;

endmodule

// ===== rtl/core/staggered_relay_pulse_driver.sv =====
// path: a command beat passes the input register, then the result register
// throughput: one command per cycle while res.ready holds, set by the single input
// register stage feeding the result register; the result register takes no new
// beat while a finished result still waits for res.ready
// reset: arst_n clears relay states, coil drivers, pulse and slot counters,
// and loads the register defaults (mask 0, pulse length 100, gap 50)
module staggered_relay_pulse_driver import srpd_pkg::*; #(
	parameter int RELAY_COUNT = RELAY_COUNT_DEF,
	parameter int SLOT_BITS   = SLOT_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	srpd_stream_if.sink   cmd,
	srpd_stream_if.sink   cfg,
	srpd_stream_if.source res
);

	localparam logic [SEL_W:0] SEL_LIMIT = (SEL_W+1)'(RELAY_COUNT);

	logic [RELAY_COUNT-1:0]            impulse_mask;
	logic [RELAY_COUNT-1:0][LEN_W-1:0] pulse_len;
	logic [LEN_W-1:0]                  gap_ms;
	logic [SLOT_BITS-1:0]              slot_wait;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      res_valid_q;
	out_item_t res_q;
	out_item_t res_d;
	logic      advance;
	logic      commit;

	logic [RELAY_COUNT-1:0] state_q;
	logic [RELAY_COUNT-1:0] state_d;
	logic [RELAY_COUNT-1:0] hit;
	logic [RELAY_COUNT-1:0] coil_d;
	logic [RELAY_COUNT-1:0] coil_all;
	logic [LEN_W-1:0]       len_sel;
	logic                   is_tick;
	logic                   sel_ok;
	logic                   change;
	logic                   reserve;

	assign cfg.ready = 1'b1;

	srpd_cfg_regs #(
		.RELAY_COUNT (RELAY_COUNT)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (cfg.valid),
		.wr           (cfg.payload),
		.impulse_mask (impulse_mask),
		.pulse_len    (pulse_len),
		.gap_ms       (gap_ms)
	);

	// input stage
	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign commit    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.payload;
		end
	end

	// decode
	for (genvar ch = 0; ch < RELAY_COUNT; ch++) begin : g_hit
		assign hit[ch] = item_s1.relay_sel == SEL_W'(ch);
	end

	assign is_tick = item_s1.operation == OP_TICK;
	assign sel_ok  = {1'b0, item_s1.relay_sel} < SEL_LIMIT;
	assign change  = commit && !is_tick && sel_ok && ((|(state_q & hit)) != item_s1.turn_on);
	assign reserve = change && (|(impulse_mask & hit));

	always_comb begin
		len_sel = '0;
		for (int ch = 0; ch < RELAY_COUNT; ch++) begin
			len_sel = len_sel | (pulse_len[ch] & {LEN_W{hit[ch]}});
		end
	end

	always_comb begin
		state_d = state_q;
		if (change) begin
			state_d = item_s1.turn_on ? (state_q | hit) : (state_q & ~hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			state_q <= state_d;
		end
	end

	srpd_slot #(
		.SLOT_BITS (SLOT_BITS)
	) u_slot (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (commit && is_tick),
		.reserve   (reserve),
		.pulse_len (len_sel),
		.gap_ms    (gap_ms),
		.slot_wait (slot_wait)
	);

	for (genvar ch = 0; ch < RELAY_COUNT; ch++) begin : g_chan
		chan_cmd_t chan_cmd;

		assign chan_cmd.tick    = commit && is_tick;
		assign chan_cmd.restart = reserve && hit[ch];

		srpd_chan #(
			.SLOT_BITS (SLOT_BITS)
		) u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (chan_cmd),
			.delay     (slot_wait),
			.pulse_len (pulse_len[ch]),
			.coil_d    (coil_d[ch])
		);
	end

	// result
	assign coil_all = (state_d & ~impulse_mask) | (coil_d & impulse_mask);

	for (genvar i = 0; i < CFG_RELAYS; i++) begin : g_out
		if (i < RELAY_COUNT) begin : g_live
			assign res_d.coil_levels[i]    = coil_all[i];
			assign res_d.logical_states[i] = state_d[i];
		end else begin : g_pad
			assign res_d.coil_levels[i]    = 1'b0;
			assign res_d.logical_states[i] = 1'b0;
		end
	end

	assign res_d.status = (!is_tick && !sel_ok) ? STATUS_BAD_SEL : STATUS_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res_d;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule
